[rtl/aaseg_pkg.sv]
// ---------------------------------------------------------------------------
// aaseg_pkg
// Shared constants, widths and the short-segment coverage table of the
// antialiased edge segment generator.
// ---------------------------------------------------------------------------
package aaseg_pkg;

    // Longest segment; longer requests saturate to it
    localparam int MAX_SEG_LEN = 64;
    // Color bits kept from the request
    localparam int COLOR_BITS  = 16;

    // Field widths
    localparam int C_COORD_W = 16;
    localparam int C_LEN_W   = 8;
    localparam int C_COLOR_W = 16;
    localparam int C_OPA_W   = 8;

    // Segment magnitude and pixel index (must hold MAX_SEG_LEN itself)
    localparam int C_IDX_W = $clog2(MAX_SEG_LEN + 1);
    // Divisor of the long ramp: twice the magnitude
    localparam int C_DEN_W = C_IDX_W + 1;
    // Iteration counter of the divider, one quotient bit per cycle
    localparam int C_DCNT_W = $clog2(C_OPA_W);

    // Magnitudes below this use the fixed table
    localparam int C_TAB_LEN = 8;

    // Mask of the color bits that pass through
    localparam logic [C_COLOR_W-1:0] C_COLOR_MASK =
        C_COLOR_W'((33'd1 << COLOR_BITS) - 33'd1);

    // Stream word widths, filled up to whole bytes
    localparam int C_S_TDATA_W = 128;
    localparam int C_M_TDATA_W = 56;

    // Coverage table of short segments: row is magnitude-1, column is pixel
    function automatic logic [7:0] ramp_val(input logic [2:0] row,
                                            input logic [2:0] col);
        logic [7:0] v;
        v = 8'd0;
        case ({row, col})
            6'o00: v = 8'd128;
            6'o10: v = 8'd64;
            6'o11: v = 8'd192;
            6'o20: v = 8'd42;
            6'o21: v = 8'd128;
            6'o22: v = 8'd212;
            6'o30: v = 8'd32;
            6'o31: v = 8'd96;
            6'o32: v = 8'd159;
            6'o33: v = 8'd223;
            6'o40: v = 8'd26;
            6'o41: v = 8'd76;
            6'o42: v = 8'd128;
            6'o43: v = 8'd178;
            6'o44: v = 8'd230;
            6'o50: v = 8'd21;
            6'o51: v = 8'd64;
            6'o52: v = 8'd106;
            6'o53: v = 8'd148;
            6'o54: v = 8'd191;
            6'o55: v = 8'd234;
            6'o60: v = 8'd18;
            6'o61: v = 8'd55;
            6'o62: v = 8'd91;
            6'o63: v = 8'd128;
            6'o64: v = 8'd164;
            6'o65: v = 8'd200;
            6'o66: v = 8'd237;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/aa_edge_segment_generator_top.sv]
// ---------------------------------------------------------------------------
// aa_edge_segment_generator_top
// Antialiased edge segment generator: one request in, one pixel out per
// position along the segment with its coverage opacity and clip flag.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*): one segment request per transfer. o_s_tready is
//   high only while the block is idle, so one request is worked at a time.
//   Master channel (o_m_*): one pixel per transfer, o_m_tlast on the final
//   pixel of the segment. A request of length zero produces no pixel.
//   Timing: magnitudes 1 to 7 go from acceptance straight to the emitting
//   state, then give one pixel per cycle while the master channel does not
//   stall. Longer segments first run the divider (one quotient bit per
//   cycle), then give one pixel per cycle by stepping the quotient and
//   remainder, again unless the master channel stalls.
//   Stall: the pixel register holds while o_m_tvalid is high and i_m_tready
//   is low; the generator waits and nothing is lost.
//   Reset: synchronous, active low; clears the sequencer and drops any
//   pixel in flight. The block comes out of reset idle and ready.
// ---------------------------------------------------------------------------
module aa_edge_segment_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request: start_x, start_y, seg_length, color, max_opa,
    //          mask_left, mask_top, mask_right, mask_bottom (lowest first)
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [aaseg_pkg::C_S_TDATA_W-1:0] i_s_tdata,
    // vertical
    input  logic                              i_s_tuser,
    // Pixel: pixel_x, pixel_y, pixel_color, pixel_opa (lowest first)
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [aaseg_pkg::C_M_TDATA_W-1:0] o_m_tdata,
    // inside_mask
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Latched request
    logic signed [aaseg_pkg::C_COORD_W-1:0] r_px, r_py;
    logic signed [aaseg_pkg::C_COORD_W-1:0] r_ml, r_mt, r_mr, r_mb;
    logic                                   r_vert;
    logic                                   r_inv;
    logic [aaseg_pkg::C_COLOR_W-1:0]        r_color;
    logic [aaseg_pkg::C_OPA_W-1:0]          r_opa;
    logic [aaseg_pkg::C_IDX_W-1:0]          r_mag;
    logic [aaseg_pkg::C_IDX_W-1:0]          r_idx;

    // Long-ramp quotient / remainder and their per-pixel steps
    logic [aaseg_pkg::C_OPA_W-1:0] r_q, r_sq;
    logic [aaseg_pkg::C_DEN_W-1:0] r_r, r_sr;

    // Pixel register
    logic                              r_m_tvalid;
    logic [aaseg_pkg::C_M_TDATA_W-1:0] r_m_tdata;
    logic                              r_m_tuser;
    logic                              r_m_tlast;

    // Request fields
    logic [aaseg_pkg::C_LEN_W-1:0] s_len;
    logic [aaseg_pkg::C_LEN_W-1:0] abs_len;
    logic [aaseg_pkg::C_IDX_W-1:0] s_mag;
    logic                          s_accept;
    logic                          s_long;

    // Divider hookup
    logic                          div_start;
    logic                          div_done;
    logic [aaseg_pkg::C_OPA_W-1:0] div_quot;
    logic [aaseg_pkg::C_DEN_W-1:0] div_rem;
    logic [aaseg_pkg::C_DEN_W-1:0] den;
    logic [aaseg_pkg::C_DEN_W:0]   twice_rem;
    logic                          twice_ge;
    logic [aaseg_pkg::C_DEN_W:0]   twice_sub;

    // Per-pixel datapath
    logic                          emit;
    logic                          last_pix;
    logic                          short_seg;
    logic [2:0]                    tab_row;
    logic [7:0]                    tab_val;
    logic [2*aaseg_pkg::C_OPA_W-1:0] prod;
    logic [aaseg_pkg::C_OPA_W-1:0] cov;
    logic [aaseg_pkg::C_OPA_W-1:0] pix_opa;
    logic                          pix_in_mask;
    logic [aaseg_pkg::C_DEN_W:0]   r_sum;
    logic                          r_wrap;
    logic [aaseg_pkg::C_DEN_W:0]   r_sum_sub;

    // Decode the request length: magnitude, saturated to the maximum
    assign s_len    = i_s_tdata[39:32];
    assign abs_len  = s_len[aaseg_pkg::C_LEN_W-1] ? (~s_len + 1'b1) : s_len;
    assign s_mag    = (abs_len > aaseg_pkg::C_LEN_W'(aaseg_pkg::MAX_SEG_LEN))
                    ? aaseg_pkg::C_IDX_W'(aaseg_pkg::MAX_SEG_LEN)
                    : aaseg_pkg::C_IDX_W'(abs_len);
    assign s_accept = i_s_tvalid && (r_state == S_IDLE);
    assign s_long   = s_mag >= aaseg_pkg::C_IDX_W'(aaseg_pkg::C_TAB_LEN);

    assign div_start = s_accept && s_long;
    assign den       = {r_mag, 1'b0};

    aaseg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_s_tdata[63:56]),
        .i_divisor  ({s_mag, 1'b0}),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Step of the ramp: 2*opa / den from the first quotient and remainder
    assign twice_rem = {div_rem, 1'b0};
    assign twice_ge  = twice_rem >= {1'b0, den};
    assign twice_sub = twice_rem - {1'b0, den};

    // Emit when the pixel register is free or being drained
    assign emit     = (r_state == S_RUN) && (!r_m_tvalid || i_m_tready);
    assign last_pix = r_idx == (r_mag - 1'b1);

    // Coverage: table times opacity for short segments, stepped quotient else
    assign short_seg = r_mag < aaseg_pkg::C_IDX_W'(aaseg_pkg::C_TAB_LEN);
    assign tab_row   = 3'(r_mag - 1'b1);
    assign tab_val   = aaseg_pkg::ramp_val(tab_row, r_idx[2:0]);
    assign prod      = r_opa * tab_val;
    assign cov       = short_seg ? prod[2*aaseg_pkg::C_OPA_W-1:aaseg_pkg::C_OPA_W] : r_q;
    assign pix_opa   = r_inv ? (r_opa - cov) : cov;

    // Clip test on the wrapped signed coordinate
    assign pix_in_mask = (r_px >= r_ml) && (r_px <= r_mr) && (r_py >= r_mt) && (r_py <= r_mb);

    // Advance the remainder, fold back once when it reaches the divisor
    assign r_sum     = {1'b0, r_r} + {1'b0, r_sr};
    assign r_wrap    = r_sum >= {1'b0, den};
    assign r_sum_sub = r_sum - {1'b0, den};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept && (s_mag != '0)) begin
                    n_state = s_long ? S_DIV : S_RUN;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (emit && last_pix) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Latch the request and walk the segment
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_px    <= i_s_tdata[15:0];
            r_py    <= i_s_tdata[31:16];
            r_inv   <= s_len[aaseg_pkg::C_LEN_W-1];
            r_color <= i_s_tdata[55:40] & aaseg_pkg::C_COLOR_MASK;
            r_opa   <= i_s_tdata[63:56];
            r_ml    <= i_s_tdata[79:64];
            r_mt    <= i_s_tdata[95:80];
            r_mr    <= i_s_tdata[111:96];
            r_mb    <= i_s_tdata[127:112];
            r_vert  <= i_s_tuser;
            r_mag   <= s_mag;
            r_idx   <= '0;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
            if (r_vert) begin
                r_py <= r_py + 1'b1;
            end else begin
                r_px <= r_px + 1'b1;
            end
        end
    end

    // Load the ramp from the divider, then step it once per pixel
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && div_done) begin
            r_q  <= div_quot;
            r_r  <= div_rem;
            r_sq <= {div_quot[aaseg_pkg::C_OPA_W-2:0], 1'b0}
                  + aaseg_pkg::C_OPA_W'(twice_ge);
            r_sr <= twice_ge ? twice_sub[aaseg_pkg::C_DEN_W-1:0]
                             : twice_rem[aaseg_pkg::C_DEN_W-1:0];
        end else if (emit) begin
            if (r_wrap) begin
                r_r <= r_sum_sub[aaseg_pkg::C_DEN_W-1:0];
                r_q <= r_q + r_sq + 1'b1;
            end else begin
                r_r <= r_sum[aaseg_pkg::C_DEN_W-1:0];
                r_q <= r_q + r_sq;
            end
        end
    end

    // Pixel register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_tdata <= {pix_opa, r_color, r_py, r_px};
            r_m_tuser <= pix_in_mask;
            r_m_tlast <= last_pix;
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

endmodule

[rtl/aaseg_div.sv]
// ---------------------------------------------------------------------------
// aaseg_div
// Restoring divider of opacity by twice the segment length, one quotient
// bit per cycle; gives quotient and remainder with a done pulse.
// ---------------------------------------------------------------------------
module aaseg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [aaseg_pkg::C_OPA_W-1:0] i_dividend,
    input  logic [aaseg_pkg::C_DEN_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [aaseg_pkg::C_OPA_W-1:0] o_quot,
    output logic [aaseg_pkg::C_DEN_W-1:0] o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [aaseg_pkg::C_DCNT_W-1:0] r_cnt;
    logic [aaseg_pkg::C_OPA_W-1:0]  r_quot;
    logic [aaseg_pkg::C_DEN_W-1:0]  r_rem;
    logic [aaseg_pkg::C_DEN_W-1:0]  r_div;

    logic [aaseg_pkg::C_DEN_W:0]    trial;
    logic                           fits;
    logic [aaseg_pkg::C_DEN_W:0]    diff;

    // Shift in the next dividend bit and try one subtraction
    assign trial = {r_rem, r_quot[aaseg_pkg::C_OPA_W-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= aaseg_pkg::C_DCNT_W'(aaseg_pkg::C_OPA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[aaseg_pkg::C_OPA_W-2:0], fits};
            r_rem  <= fits ? diff[aaseg_pkg::C_DEN_W-1:0] : trial[aaseg_pkg::C_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[bench/aaseg_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// aaseg_checker
// Watches both stream channels of the edge segment generator. It predicts
// the pixels of every accepted segment request, then compares each accepted
// pixel with the oldest prediction. It reports the mismatch count and the
// number of pixels still outstanding.
// ---------------------------------------------------------------------------
module aaseg_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // start_x, start_y, seg_length, color, max_opa,
    // mask_left, mask_top, mask_right, mask_bottom (lowest first)
    input  logic [aaseg_pkg::C_S_TDATA_W-1:0] i_s_tdata,
    // vertical
    input  logic                              i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // pixel_x, pixel_y, pixel_color, pixel_opa (lowest first)
    input  logic [aaseg_pkg::C_M_TDATA_W-1:0] i_m_tdata,
    // inside_mask
    input  logic                              i_m_tuser,
    input  logic                              i_m_tlast,
    output int                                o_fail_count,
    output int                                o_pixels_pending
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] color;
        logic [7:0]  opa;
        logic        in_mask;
        logic        last;
    } t_pixel;

    t_pixel expected_pixels[$];
    int     mismatches = 0;

    // Fixed coverage of short segments, listed from the first pixel on
    function automatic int short_ramp(input int mag, input int idx);
        logic [55:0] row;
        case (mag)
            1:       row = {8'd128, 48'd0};
            2:       row = {8'd64, 8'd192, 40'd0};
            3:       row = {8'd42, 8'd128, 8'd212, 32'd0};
            4:       row = {8'd32, 8'd96, 8'd159, 8'd223, 24'd0};
            5:       row = {8'd26, 8'd76, 8'd128, 8'd178, 8'd230, 16'd0};
            6:       row = {8'd21, 8'd64, 8'd106, 8'd148, 8'd191, 8'd234, 8'd0};
            default: row = {8'd18, 8'd55, 8'd91, 8'd128, 8'd164, 8'd200, 8'd237};
        endcase
        return int'(row[(6 - idx) * 8 +: 8]);
    endfunction

    // Coverage of one pixel: table for short segments, exact ramp otherwise
    function automatic logic [7:0] pixel_coverage(input int mag, input int idx,
                                                  input int opa);
        if (mag < 8)
            return 8'((short_ramp(mag, idx) * opa) >> 8);
        return 8'(((2 * idx + 1) * opa) / (2 * mag));
    endfunction

    // Queue the pixels that one segment request produces
    task automatic predict_segment(input logic [aaseg_pkg::C_S_TDATA_W-1:0] req,
                                   input logic vert);
        logic [15:0]        sx;
        logic [15:0]        sy;
        logic [15:0]        px;
        logic [15:0]        py;
        logic signed [7:0]  len8;
        logic [7:0]         opa;
        logic signed [15:0] ml;
        logic signed [15:0] mt;
        logic signed [15:0] mr;
        logic signed [15:0] mb;
        int                 seg_len;
        int                 mag;
        bit                 invert;
        t_pixel             p;
        sx      = req[15:0];
        sy      = req[31:16];
        len8    = req[39:32];
        opa     = req[63:56];
        ml      = req[79:64];
        mt      = req[95:80];
        mr      = req[111:96];
        mb      = req[127:112];
        seg_len = len8;
        invert  = (seg_len < 0);
        mag     = invert ? -seg_len : seg_len;
        if (mag > aaseg_pkg::MAX_SEG_LEN)
            mag = aaseg_pkg::MAX_SEG_LEN;
        for (int i = 0; i < mag; i++) begin
            px       = vert ? sx : sx + 16'(i);
            py       = vert ? sy + 16'(i) : sy;
            p.x      = px;
            p.y      = py;
            p.color  = req[55:40] & aaseg_pkg::C_COLOR_MASK;
            p.opa    = pixel_coverage(mag, i, int'(opa));
            if (invert)
                p.opa = opa - p.opa;
            p.in_mask = ($signed(px) >= ml) && ($signed(px) <= mr) &&
                        ($signed(py) >= mt) && ($signed(py) <= mb);
            p.last   = (i == mag - 1);
            expected_pixels.push_back(p);
        end
    endtask

    // Compare pixels first, then queue the request accepted at this edge
    always @(posedge i_clk) begin : monitor
        t_pixel got;
        t_pixel want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got.x       = i_m_tdata[15:0];
                got.y       = i_m_tdata[31:16];
                got.color   = i_m_tdata[47:32];
                got.opa     = i_m_tdata[55:48];
                got.in_mask = i_m_tuser;
                got.last    = i_m_tlast;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected pixel x=%0d y=%0d color=%h opa=%0d in=%b last=%b",
                                 $realtime, $signed(got.x), $signed(got.y), got.color,
                                 got.opa, got.in_mask, got.last);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                        got.opa !== want.opa || got.in_mask !== want.in_mask ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: pixel mismatch", $realtime);
                            $display("  expected x=%0d y=%0d color=%h opa=%0d in=%b last=%b",
                                     $signed(want.x), $signed(want.y), want.color,
                                     want.opa, want.in_mask, want.last);
                            $display("  actual   x=%0d y=%0d color=%h opa=%0d in=%b last=%b",
                                     $signed(got.x), $signed(got.y), got.color,
                                     got.opa, got.in_mask, got.last);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_segment(i_s_tdata, i_s_tuser);
        end
        o_fail_count     <= mismatches;
        o_pixels_pending <= expected_pixels.size();
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives segment requests into the edge segment generator: a directed set
// covering every short ramp, saturation, inversion, coordinate wrap and clip
// corners, then random requests with random idling on both channels and one
// long output stall. A checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 160;
    localparam int CALM_ITEMS   = 30;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_ITEMS   = 10;
    localparam int DRAIN_CYCLES = 100;

    // Packed exactly as the request word, start_x in the lowest bits
    typedef struct packed {
        logic signed [15:0] mask_bottom;
        logic signed [15:0] mask_right;
        logic signed [15:0] mask_top;
        logic signed [15:0] mask_left;
        logic [7:0]         max_opa;
        logic [15:0]        color;
        logic signed [7:0]  seg_length;
        logic signed [15:0] start_y;
        logic signed [15:0] start_x;
    } t_segment_req;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [aaseg_pkg::C_S_TDATA_W-1:0] i_s_tdata;
    logic                              i_s_tuser;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [aaseg_pkg::C_M_TDATA_W-1:0] o_m_tdata;
    logic                              o_m_tuser;
    logic                              o_m_tlast;
    int                                fail_count;
    int                                pixels_pending;
    int                                cycle_count = 0;
    bit                                hold_off_go = 1'b0;
    bit                                calm = 1'b0;

    aa_edge_segment_generator_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    aaseg_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_s_tuser        (i_s_tuser),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tuser        (o_m_tuser),
        .i_m_tlast        (o_m_tlast),
        .o_fail_count     (fail_count),
        .o_pixels_pending (pixels_pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Pixel receiver: random stalls, one long hold-off, none at the end
    initial begin : receiver
        int  span;
        bit  hold_done;
        hold_done  = 1'b0;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_go && !hold_done) begin
                hold_done = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (calm) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                span = $urandom_range(1, 19);
                i_m_tready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else begin
                span = $urandom_range(1, 30);
                i_m_tready <= 1'b1;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    function automatic t_segment_req make_segment(
        input int sx, input int sy, input int len, input int color, input int opa,
        input int ml, input int mt, input int mr, input int mb);
        t_segment_req r;
        r.start_x     = 16'(sx);
        r.start_y     = 16'(sy);
        r.seg_length  = 8'(len);
        r.color       = 16'(color);
        r.max_opa     = 8'(opa);
        r.mask_left   = 16'(ml);
        r.mask_top    = 16'(mt);
        r.mask_right  = 16'(mr);
        r.mask_bottom = 16'(mb);
        return r;
    endfunction

    // Offer one request, hold it until accepted, then maybe idle a burst
    task automatic offer_segment(input t_segment_req r, input logic vert,
                                 input bit with_gaps);
        int gap;
        i_s_tdata  <= r;
        i_s_tuser  <= vert;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (with_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly short segments around a nearby clip rectangle, some wild ones
    task automatic random_segment(output t_segment_req r, output logic vert);
        int pick;
        int len;
        int cx;
        int cy;
        int ml;
        int mt;
        int mr;
        int mb;
        int opa;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            len = int'($urandom_range(0, 32)) - 16;
        else if (pick < 85)
            len = $urandom_range(0, 1) ? int'($urandom_range(17, 64))
                                       : -int'($urandom_range(17, 64));
        else
            len = int'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            cx = int'($urandom_range(0, 65535));
            cy = int'($urandom_range(0, 65535));
        end else if (pick < 32) begin
            cx = 32767 - int'($urandom_range(0, 70));
            cy = 32767 - int'($urandom_range(0, 70));
        end else begin
            cx = int'($urandom_range(0, 400)) - 200;
            cy = int'($urandom_range(0, 400)) - 200;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            ml = int'($urandom_range(0, 65535));
            mt = int'($urandom_range(0, 65535));
            mr = int'($urandom_range(0, 65535));
            mb = int'($urandom_range(0, 65535));
        end else if (pick < 20) begin
            ml = cx + 10;
            mr = cx - 10;
            mt = cy - 40;
            mb = cy + 40;
        end else begin
            ml = cx + int'($urandom_range(0, 90)) - 70;
            mr = ml + int'($urandom_range(0, 80));
            mt = cy + int'($urandom_range(0, 90)) - 70;
            mb = mt + int'($urandom_range(0, 80));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)
            opa = 0;
        else if (pick < 20)
            opa = 255;
        else
            opa = int'($urandom_range(0, 255));
        r    = make_segment(cx, cy, len, int'($urandom_range(0, 65535)), opa,
                            ml, mt, mr, mb);
        vert = 1'($urandom_range(0, 1));
    endtask

    initial begin : stimulus
        t_segment_req req;
        logic         vert;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero length: nothing comes out
        offer_segment(make_segment(10, 20, 0, 'h1234, 200, 0, 0, 100, 100), 1'b0, 1'b1);
        // Every short table row, the longer ones crossing the right clip edge
        for (int n = 1; n <= 7; n++)
            offer_segment(make_segment(96, 50, n, 'hFFFF, 255, 0, 0, 100, 100), 1'b0, 1'b1);
        // Inverted short ramps, vertical
        offer_segment(make_segment(5, -3, -1, 0, 200, 0, 0, 10, 10), 1'b1, 1'b1);
        offer_segment(make_segment(5, -3, -4, 0, 200, 0, 0, 10, 10), 1'b1, 1'b1);
        offer_segment(make_segment(5, -3, -7, 0, 200, 0, 0, 10, 10), 1'b1, 1'b1);
        // Long ramps up to the limit, and saturation beyond it
        offer_segment(make_segment(0, 0, 8, 'hA5A5, 255, 0, 0, 3, 0), 1'b0, 1'b1);
        offer_segment(make_segment(0, 0, 64, 'h5A5A, 255, -5, 0, 5, 30), 1'b1, 1'b1);
        offer_segment(make_segment(-20, 7, -64, 'h00FF, 255, -10, 7, 10, 7), 1'b0, 1'b1);
        offer_segment(make_segment(1, 1, 127, 'hFF00, 128, 0, 0, 40, 40), 1'b0, 1'b1);
        offer_segment(make_segment(1, 1, -128, 'h8000, 255, 0, 0, 40, 40), 1'b1, 1'b1);
        offer_segment(make_segment(1, 1, -65, 'h0001, 1, 0, 0, 40, 40), 1'b0, 1'b1);
        // Coordinates wrapping past the positive limit
        offer_segment(make_segment(32760, 0, 16, 'h1111, 99, 32750, -1, 32767, 1),
                      1'b0, 1'b1);
        offer_segment(make_segment(3, 32767, 9, 'h2222, 77, 0, -32768, 5, -32760),
                      1'b1, 1'b1);
        // Empty rectangle, zero opacity, most negative start, full rectangle
        offer_segment(make_segment(45, 0, 12, 'h3333, 180, 50, -5, 40, 5), 1'b0, 1'b1);
        offer_segment(make_segment(0, 0, 20, 'h4444, 0, 0, 0, 30, 30), 1'b0, 1'b1);
        offer_segment(make_segment(-32768, -32768, 40, 'h8001, 255, -32768, -32768,
                                   -32750, -32768), 1'b0, 1'b1);
        offer_segment(make_segment(0, 0, 3, 'hFFFF, 255, -32768, -32768, 32767, 32767),
                      1'b1, 1'b1);

        // Random requests; fill the block behind one long output stall
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == HOLD_AT)
                hold_off_go = 1'b1;
            random_segment(req, vert);
            offer_segment(req, vert, !(k >= HOLD_AT && k < HOLD_AT + HOLD_ITEMS));
        end

        // Final stretch with no idling on either side
        calm = 1'b1;
        for (int k = 0; k < CALM_ITEMS; k++) begin
            random_segment(req, vert);
            offer_segment(req, vert, 1'b0);
        end
        i_s_tvalid <= 1'b0;

        // Drain, then let the block settle
        do
            @(posedge i_clk);
        while (pixels_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pixels_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
